FILE: hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Shared types and constants for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int WORD_WIDTH_DEFAULT = 32;

    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        req_kind_t                 req_type;
        logic signed [DATA_W-1:0]  data_in;
    } deq_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data_out;
        status_t                   status;
        logic [TOTAL_W-1:0]        entry_total;
    } deq_out_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take the request, update pointers, issue RAM access
        logic finish;   // capture RAM read data into the response
    } deq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_read;  // pending request is a pop on a non-empty queue
        logic out_busy;   // response register holds a transaction not taken
    } deq_sts_t;

endpackage

FILE: hw/rtl/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque controller
// Sequences one request at a time: accept, then for a stored-word pop collect the read data in READ.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  deq_pkg::deq_sts_t sts,
    output deq_pkg::deq_cmd_t cmd
);

    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE) && !sts.out_busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.accept = 1'b1;
                    if (sts.need_read)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/deq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque datapath
// Ring pointers, entry count, ring store and the response register.
// ----------------------------------------------------------------------------
module deq_datapath #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  deq_pkg::deq_in_t  req,
    input  deq_pkg::deq_cmd_t cmd,
    output deq_pkg::deq_sts_t sts,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output deq_pkg::deq_out_t rsp
);

    import deq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    deq_out_t      rsp_reg, rsp_next;
    logic          rsp_valid_reg;

    logic          full, empty;
    logic [PW-1:0] front_dec, front_inc;
    logic [PW:0]   back_sum, last_sum;
    logic [PW-1:0] back_slot, last_slot;

    logic                           wr_en, rd_en;
    logic [PW-1:0]                  wr_addr, rd_addr;
    logic [DATA_W+WORD_WIDTH-1:0]   wide_in;
    logic [WORD_WIDTH-1:0]          rd_word;
    logic [WORD_WIDTH+DATA_W-1:0]   wide_rd;
    logic [CW+TOTAL_W-1:0]          count_ext;
    logic                           need_read;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    // count <= DEPTH, so each sum stays below 2*DEPTH and one subtract wraps it
    assign back_sum  = {1'b0, front_reg} + (PW+1)'(count_reg);
    assign last_sum  = back_sum - 1'b1;
    assign back_slot = (back_sum >= (PW+1)'(DEPTH)) ? PW'(back_sum - (PW+1)'(DEPTH))
                                                    : back_sum[PW-1:0];
    assign last_slot = (last_sum >= (PW+1)'(DEPTH)) ? PW'(last_sum - (PW+1)'(DEPTH))
                                                    : last_sum[PW-1:0];

    assign wide_in = {{WORD_WIDTH{req.data_in[DATA_W-1]}}, req.data_in};

    always_comb
    begin
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = front_dec;
        rd_addr    = front_reg;
        front_next = front_reg;
        count_next = count_reg;
        need_read  = 1'b0;
        unique case (req.req_type)
            REQ_PUSH_FRONT:
            begin
                if (!full)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_PUSH_BACK:
            begin
                if (!full)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = back_slot;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_POP_FRONT:
            begin
                if (!empty)
                begin
                    rd_en      = 1'b1;
                    need_read  = 1'b1;
                    rd_addr    = front_reg;
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_POP_BACK:
            begin
                if (!empty)
                begin
                    rd_en      = 1'b1;
                    need_read  = 1'b1;
                    rd_addr    = last_slot;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign count_ext = {{TOTAL_W{1'b0}}, count_next};
    assign wide_rd   = {{DATA_W{rd_word[WORD_WIDTH-1]}}, rd_word};

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_next.entry_total = count_ext[TOTAL_W-1:0];
        if (req.req_type == REQ_PUSH_FRONT || req.req_type == REQ_PUSH_BACK)
        begin
            rsp_next.data_out = '0;
            rsp_next.status   = full ? ST_FULL : ST_DONE;
        end
        else
        begin
            rsp_next.data_out = '1;
            rsp_next.status   = empty ? ST_EMPTY : ST_DONE;
        end
    end

    deq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.accept && wr_en),
        .wr_addr (wr_addr),
        .wr_data (wide_in[WORD_WIDTH-1:0]),
        .rd_en   (cmd.accept && rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if ((cmd.accept && !need_read) || cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rsp_reg <= rsp_next;
        end
        else if (cmd.finish)
        begin
            rsp_reg.data_out <= wide_rd[DATA_W-1:0];
        end
    end

    assign sts.need_read = need_read;
    assign sts.out_busy  = rsp_valid_reg && !rsp_ready;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;

endmodule

FILE: hw/rtl/double_ended_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed words in a ring-organized RAM.
// ----------------------------------------------------------------------------
// A bounded double-ended queue of up to DEPTH signed words. Each request
// transaction pushes or pops at either end and yields exactly one response
// transaction carrying the popped word (-1 on an empty pop, 0 on pushes),
// a status (done, empty on pop, full on push) and the entry count after the
// request. A push into a full queue is dropped. Pushes and empty pops are
// answered the cycle after acceptance. A stored-word pop detours through
// READ for the registered read port of the ring RAM; the next request
// waits for its data. Pushes sustain one per cycle while responses are
// consumed. The response register decouples the two sides: a new request
// is taken in the same cycle the previous response is consumed. No
// clearing pass is needed after reset; only occupied slots are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              req_valid,
    output logic              req_ready,
    input  deq_pkg::deq_in_t  req,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output deq_pkg::deq_out_t rsp
);

    import deq_pkg::*;

    deq_cmd_t cmd;
    deq_sts_t sts;

    // Controller: IDLE accepts a request when the response register is free
    // (or draining this cycle); pops of stored data detour through READ.
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: front pointer, entry count, ring RAM and response register.
    deq_datapath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: hw/rtl/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque checker
// Port-level assertions for the double-ended queue core, bound to the top.
// ----------------------------------------------------------------------------
module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input deq_pkg::deq_in_t  req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input deq_pkg::deq_out_t rsp
);

    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W+TOTAL_W-1:0] FULL_EXT = (CNT_W+TOTAL_W)'(DEPTH);

    // stalled request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.data_out == -32'sd1
            && rsp.entry_total == '0)
        else $error("empty pop response malformed");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.data_out == '0
            && rsp.entry_total == FULL_EXT[TOTAL_W-1:0])
        else $error("full push response malformed");

    // one request in flight: no new request while the response is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request accepted while response stalled");

endmodule

bind double_ended_queue_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
